>>> rtl/core/spf_pkg.sv
`default_nettype none

package spf_pkg;

   localparam int FRAME_BYTES_DEFAULT = 32;
   localparam int QUEUE_DEPTH         = 2;
   localparam int INDEX_W             = 5;

   localparam logic [15:0] CRC_INIT    = 16'hFFFF;
   localparam logic [15:0] CRC_POLY    = 16'h1021;
   localparam logic [15:0] CRC_MSB     = 16'h8000;
   localparam logic [15:0] PH_MAX      = 16'd1400;
   localparam logic [15:0] U16_MAX     = 16'hFFFF;
   localparam logic [15:0] NODE_ID_RST = 16'd1;

   typedef struct packed {
      logic [7:0]         msg_kind;
      logic signed [23:0] tds_ppm;
      logic signed [23:0] ph_centi;
      logic signed [23:0] turbidity_centi;
      logic signed [23:0] flow_centi;
      logic signed [23:0] water_level;
      logic [7:0]         battery_pct;
   } req_type;

   typedef struct packed {
      logic [7:0]         frame_byte;
      logic [INDEX_W-1:0] byte_index;
      logic               last_byte;
   } rsp_type;

   // clamped record as it sits in the queue
   typedef struct packed {
      logic [15:0] node_id;
      logic [7:0]  msg_kind;
      logic [15:0] tds;
      logic [15:0] ph;
      logic [15:0] turb;
      logic [15:0] flow;
      logic [15:0] level;
      logic [7:0]  battery;
   } record_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

endpackage

`default_nettype wire

>>> rtl/core/spf_front.sv
`default_nettype none

module spf_front (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 csr_we,
   input  wire logic [15:0]          csr_wdata,
   input  wire logic                 req_push,
   output logic                      req_full,
   input  wire spf_pkg::req_type     req_data,
   input  wire spf_pkg::q_status_type q_status,
   output logic                      q_push,
   output spf_pkg::record_type       q_wdata
);
   import spf_pkg::*;

   logic [15:0] node_id_ff, node_id_in;
   logic        valid_ff, valid_in;
   record_type  rec_ff, rec_in;
   logic        accept;

   function automatic logic [15:0] clamp24(input logic signed [23:0] v,
                                           input logic [15:0] hi);
      logic [15:0] r;
      if (v[23])
         r = 16'd0;
      else if (v[22:0] > {7'd0, hi})
         r = hi;
      else
         r = v[15:0];
      return r;
   endfunction

   assign req_full = valid_ff & q_status.full;
   assign accept   = req_push & ~req_full;
   assign q_push   = valid_ff & ~q_status.full;
   assign q_wdata  = rec_ff;

   always_comb begin
      node_id_in = csr_we ? csr_wdata : node_id_ff;
      valid_in   = accept | (valid_ff & ~q_push);
      rec_in     = rec_ff;
      if (accept) begin
         rec_in.node_id  = node_id_ff;
         rec_in.msg_kind = req_data.msg_kind;
         rec_in.tds      = clamp24(req_data.tds_ppm, U16_MAX);
         rec_in.ph       = clamp24(req_data.ph_centi, PH_MAX);
         rec_in.turb     = clamp24(req_data.turbidity_centi, U16_MAX);
         rec_in.flow     = clamp24(req_data.flow_centi, U16_MAX);
         rec_in.level    = clamp24(req_data.water_level, U16_MAX);
         rec_in.battery  = req_data.battery_pct;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         node_id_ff <= NODE_ID_RST;
         valid_ff   <= 1'b0;
      end else begin
         node_id_ff <= node_id_in;
         valid_ff   <= valid_in;
      end
      rec_ff <= rec_in;
   end

endmodule

`default_nettype wire

>>> rtl/core/spf_queue.sv
`default_nettype none

module spf_queue (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  push,
   input  wire spf_pkg::record_type   wdata,
   input  wire logic                  pop,
   output spf_pkg::record_type        rdata,
   output spf_pkg::q_status_type      status
);
   import spf_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   record_type       entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
      logic [PTR_W-1:0] r;
      if (p == PTR_W'(QUEUE_DEPTH - 1))
         r = '0;
      else
         r = p + PTR_W'(1);
      return r;
   endfunction

   assign status.full  = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);
   assign rdata        = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? bump(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop  ? bump(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop)
         count_in = count_ff + CNT_W'(1);
      else if (pop && !push)
         count_in = count_ff - CNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push)
         entry_ff[wr_ptr_ff] <= wdata;
   end

endmodule

`default_nettype wire

>>> rtl/core/spf_back.sv
`default_nettype none

module spf_back #(
   parameter int FRAME_BYTES = spf_pkg::FRAME_BYTES_DEFAULT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire spf_pkg::record_type   q_rdata,
   input  wire spf_pkg::q_status_type q_status,
   output logic                      q_pop,
   output logic                      rsp_empty,
   input  wire logic                  rsp_pop,
   output spf_pkg::rsp_type           rsp_data
);
   import spf_pkg::*;

   localparam int PW = $clog2(FRAME_BYTES);
   localparam logic [PW-1:0] CRC_HI_POS = PW'(FRAME_BYTES - 2);
   localparam logic [PW-1:0] LAST_POS   = PW'(FRAME_BYTES - 1);

   logic [PW-1:0] pos_ff, pos_in;
   logic [15:0]   crc_ff, crc_in;
   logic          out_valid_ff, out_valid_in;
   rsp_type       out_ff, out_in;
   logic          step;
   logic [7:0]    byte_sel;

   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'd0};
      for (int k = 0; k < 8; k++) begin
         if ((c & CRC_MSB) != 16'd0)
            c = {c[14:0], 1'b0} ^ CRC_POLY;
         else
            c = {c[14:0], 1'b0};
      end
      return c;
   endfunction

   // advance when a record waits and the output register is free or draining
   assign step      = ~q_status.empty & (~out_valid_ff | rsp_pop);
   assign q_pop     = step & (pos_ff == LAST_POS);
   assign rsp_empty = ~out_valid_ff;
   assign rsp_data  = out_ff;

   always_comb begin
      byte_sel = 8'd0;
      if (pos_ff == CRC_HI_POS)
         byte_sel = crc_ff[15:8];
      else if (pos_ff == LAST_POS)
         byte_sel = crc_ff[7:0];
      else begin
         case (pos_ff)
            PW'(0):  byte_sel = q_rdata.node_id[15:8];
            PW'(1):  byte_sel = q_rdata.node_id[7:0];
            PW'(2):  byte_sel = q_rdata.msg_kind;
            PW'(3):  byte_sel = q_rdata.tds[15:8];
            PW'(4):  byte_sel = q_rdata.tds[7:0];
            PW'(5):  byte_sel = q_rdata.ph[15:8];
            PW'(6):  byte_sel = q_rdata.ph[7:0];
            PW'(7):  byte_sel = q_rdata.turb[15:8];
            PW'(8):  byte_sel = q_rdata.turb[7:0];
            PW'(9):  byte_sel = q_rdata.flow[15:8];
            PW'(10): byte_sel = q_rdata.flow[7:0];
            PW'(11): byte_sel = q_rdata.level[15:8];
            PW'(12): byte_sel = q_rdata.level[7:0];
            PW'(13): byte_sel = q_rdata.battery;
            default: byte_sel = 8'd0;
         endcase
      end
   end

   always_comb begin
      pos_in       = pos_ff;
      crc_in       = crc_ff;
      out_in       = out_ff;
      out_valid_in = out_valid_ff & ~rsp_pop;
      if (step) begin
         out_valid_in      = 1'b1;
         out_in.frame_byte = byte_sel;
         out_in.byte_index = INDEX_W'(pos_ff);
         out_in.last_byte  = (pos_ff == LAST_POS);
         if (pos_ff == LAST_POS) begin
            pos_in = '0;
            crc_in = CRC_INIT;
         end else begin
            pos_in = pos_ff + PW'(1);
            // hold the checksum once the covered bytes are done
            if (pos_ff < CRC_HI_POS)
               crc_in = crc_byte(crc_ff, byte_sel);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         crc_ff       <= CRC_INIT;
         out_valid_ff <= 1'b0;
      end else begin
         pos_ff       <= pos_in;
         crc_ff       <= crc_in;
         out_valid_ff <= out_valid_in;
      end
      out_ff <= out_in;
   end

   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= LAST_POS)
      else $error("frame position past end of frame");

   a_last_index: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_ff.last_byte |-> out_ff.byte_index == INDEX_W'(LAST_POS))
      else $error("last byte flagged at wrong position");

   a_frame_wrap: assert property (@(posedge clock) disable iff (reset)
      step && pos_ff == LAST_POS |=> pos_ff == '0 && crc_ff == CRC_INIT)
      else $error("checksum or position not restarted after frame");

   a_pop_on_last: assert property (@(posedge clock) disable iff (reset)
      q_pop |=> out_valid_ff && out_ff.last_byte)
      else $error("record released without emitting its last byte");

endmodule

`default_nettype wire

>>> rtl/core/sensor_packet_framer_crc16_unit.sv
// Sensor packet framer with CRC-16/CCITT-FALSE.
// Request side: drive req_data and raise req_push; the request is taken at a
// clock edge where req_full is low. Each request is one reading record; the
// signed values are clamped and the record becomes a FRAME_BYTES byte frame.
// Response side: while rsp_empty is low, rsp_data holds the oldest frame byte
// with its index (modulo 32) and a last_byte flag on the final CRC byte; raise
// rsp_pop to take it.
// csr_we/csr_wdata write the 16-bit node id (reset value 1); the user is to
// write it only while idle, which the block itself does not enforce. A
// request is registered in the input stage, written into the queue, and
// then its first byte is registered in the output register. Throughput: one
// byte per cycle while the receiver pops each byte; while records wait,
// frames follow each other with no gap. The two-entry queue and the input
// stage hold up to three records: the frame being sent and two more waiting.
// When the receiver stalls, the current byte holds and the serializer waits;
// once the queue and the input stage are both full, req_full rises.
// Reset (synchronous, active high) drops all queued records and partial
// frames and restores the node id to 1.
`default_nettype none

module sensor_packet_framer_crc16_unit #(
   parameter int FRAME_BYTES = spf_pkg::FRAME_BYTES_DEFAULT
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             csr_we,
   input  wire logic [15:0]      csr_wdata,
   input  wire logic             req_push,
   output logic                  req_full,
   input  wire spf_pkg::req_type req_data,
   output logic                  rsp_empty,
   input  wire logic             rsp_pop,
   output spf_pkg::rsp_type      rsp_data
);
   import spf_pkg::*;

   logic         q_push;
   logic         q_pop;
   record_type   q_wdata;
   record_type   q_rdata;
   q_status_type q_status;

   spf_front u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .q_status  (q_status),
      .q_push    (q_push),
      .q_wdata   (q_wdata)
   );

   spf_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (q_push),
      .wdata  (q_wdata),
      .pop    (q_pop),
      .rdata  (q_rdata),
      .status (q_status)
   );

   spf_back #(
      .FRAME_BYTES (FRAME_BYTES)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_rdata   (q_rdata),
      .q_status  (q_status),
      .q_pop     (q_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire
